// ----- src/lca_pkg.sv -----
`default_nettype none

package lca_pkg;

    // Field widths fixed by the stream format
    localparam int NODE_W   = 10;
    localparam int WEIGHT_W = 16;
    localparam int DEPTH_W  = 10;
    localparam int DIST_W   = 26;

    // Saturation limits
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = {DEPTH_W{1'b1}};
    localparam logic [DIST_W-1:0]  DIST_MAX  = {DIST_W{1'b1}};

    // Parameter defaults for the top level
    localparam int NODES_DEF       = 1024;
    localparam int LEVELS_DEF      = 10;
    localparam int WEIGHT_BITS_DEF = 16;

    // Request kinds carried on s_tuser
    localparam logic REQ_ADD   = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Per-node record: root distance over depth
    typedef struct packed {
        logic [DIST_W-1:0]  root_dist;
        logic [DEPTH_W-1:0] depth;
    } info_t;

endpackage

`default_nettype wire

// ----- src/tree_lca_distance_engine_unit.sv -----
`default_nettype none
// Channel | Dir | tvalid/tready     | tdata bits (low first)                    | tuser
// s_      | in  | s_tvalid/s_tready | node_a 9:0, node_b 19:10, edge_weight 35:20 | req_type
// m_      | out | m_tvalid/m_tready | lca_node 9:0, path_distance 35:10          | different_trees
//
// One item at a time; s_tready is high only while idle. A query also waits while
// the result register is still full at its end. Each lifting level walks the
// ancestor RAM through its registered read port. Adds of node 0 or of a node
// >= NODES are dropped without a write. Reset (aresetn low, synchronous) clears
// only control; no memory clearing pass.

module tree_lca_distance_engine_unit
    import lca_pkg::*;
#(
    parameter int NODES       = NODES_DEF,
    parameter int LEVELS      = LEVELS_DEF,
    parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,  // node_a, node_b, edge_weight, zero pad
    input  wire logic [0:0]  s_tuser,  // req_type
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [39:0] m_tdata,  // lca_node, path_distance, zero pad
    output logic      [0:0]  m_tuser   // different_trees
);

    localparam int IDX_W     = $clog2(NODES);
    localparam int LVL_W     = $clog2(LEVELS);
    localparam int ANC_DEPTH = NODES << LVL_W;
    localparam logic [LVL_W-1:0] LAST_LVL = LVL_W'(LEVELS - 1);
    localparam logic [WEIGHT_W-1:0] WMASK = (WEIGHT_BITS >= WEIGHT_W) ?
        {WEIGHT_W{1'b1}} : WEIGHT_W'((32'd1 << WEIGHT_BITS) - 32'd1);

    // Sequencer state codes
    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_A_INFO   = 4'd1;
    localparam logic [3:0] ST_A_INFOWR = 4'd2;
    localparam logic [3:0] ST_A_RD     = 4'd3;
    localparam logic [3:0] ST_A_WR     = 4'd4;
    localparam logic [3:0] ST_Q_INFO   = 4'd5;
    localparam logic [3:0] ST_Q_SWAP   = 4'd6;
    localparam logic [3:0] ST_Q_LIFT   = 4'd7;
    localparam logic [3:0] ST_Q_CHECK  = 4'd8;
    localparam logic [3:0] ST_Q_PASS   = 4'd9;
    localparam logic [3:0] ST_Q_PAR    = 4'd10;
    localparam logic [3:0] ST_Q_DIST   = 4'd11;

    // Input fields
    logic [NODE_W-1:0]   in_node_a;
    logic [NODE_W-1:0]   in_node_b;
    logic [WEIGHT_W-1:0] in_weight;
    logic [NODE_W-1:0]   a_idx;
    logic [NODE_W-1:0]   b_idx;
    logic                add_ok;

    assign in_node_a = s_tdata[9:0];
    assign in_node_b = s_tdata[19:10];
    assign in_weight = s_tdata[35:20];

    // Out-of-range node numbers map onto the sentinel
    assign a_idx  = (32'(in_node_a) < NODES) ? in_node_a : '0;
    assign b_idx  = (32'(in_node_b) < NODES) ? in_node_b : '0;
    assign add_ok = (in_node_a != '0) && (32'(in_node_a) < NODES);

    // Registers
    logic [3:0]          state_reg,  state_next;
    logic [NODE_W-1:0]   node_reg,   node_next;
    logic [NODE_W-1:0]   par_reg,    par_next;
    logic [WEIGHT_W-1:0] weight_reg, weight_next;
    logic [NODE_W-1:0]   u_reg,      u_next;
    logic [NODE_W-1:0]   v_reg,      v_next;
    logic [NODE_W-1:0]   lca_reg,    lca_next;
    logic [LVL_W-1:0]    lvl_reg,    lvl_next;
    logic [LEVELS-1:0]   gap_reg,    gap_next;
    logic                pend_reg,   pend_next;
    logic [DIST_W:0]     sum_reg,    sum_next;
    logic                za_reg,     zb_reg;
    logic                m_valid_reg, m_valid_next;
    logic [NODE_W-1:0]   m_lca_reg,  m_lca_next;
    logic [DIST_W-1:0]   m_dist_reg, m_dist_next;
    logic                m_diff_reg, m_diff_next;

    // Memory ports
    logic [NODE_W-1:0]        rd_node_a, rd_node_b;
    logic [LVL_W-1:0]         rd_lvl;
    logic                     inf_we, anc_we;
    info_t                    inf_wdata;
    logic [NODE_W-1:0]        anc_wdata;
    logic [IDX_W+LVL_W-1:0]   anc_waddr;
    logic [$bits(info_t)-1:0] inf_qa_raw, inf_qb_raw;
    logic [NODE_W-1:0]        anc_qa_raw, anc_qb_raw;
    info_t                    inf_a, inf_b;
    logic [NODE_W-1:0]        anc_a, anc_b;

    // Working values
    logic                  out_free;
    logic [NODE_W-1:0]     u_cur, u_pass, v_pass;
    logic [DIST_W:0]       dsum;
    logic [DIST_W+1:0]     pdiff;
    logic [DEPTH_W-1:0]    gap_raw;

    assign anc_waddr = {IDX_W'(node_reg), lvl_reg};

    lca_ram #(
        .WIDTH($bits(info_t)),
        .DEPTH(NODES)
    ) u_info_ram (
        .aclk   (aclk),
        .we     (inf_we),
        .waddr  (IDX_W'(node_reg)),
        .wdata  (inf_wdata),
        .ra_addr(IDX_W'(rd_node_a)),
        .ra_data(inf_qa_raw),
        .rb_addr(IDX_W'(rd_node_b)),
        .rb_data(inf_qb_raw)
    );

    lca_ram #(
        .WIDTH(NODE_W),
        .DEPTH(ANC_DEPTH)
    ) u_anc_ram (
        .aclk   (aclk),
        .we     (anc_we),
        .waddr  (anc_waddr),
        .wdata  (anc_wdata),
        .ra_addr({IDX_W'(rd_node_a), rd_lvl}),
        .ra_data(anc_qa_raw),
        .rb_addr({IDX_W'(rd_node_b), rd_lvl}),
        .rb_data(anc_qb_raw)
    );

    // Node 0 reads as all zero in both memories
    assign inf_a = za_reg ? '0 : info_t'(inf_qa_raw);
    assign inf_b = zb_reg ? '0 : info_t'(inf_qb_raw);
    assign anc_a = za_reg ? '0 : anc_qa_raw;
    assign anc_b = zb_reg ? '0 : anc_qb_raw;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);

    // Lifted node: fresh RAM data when a lift read is in flight
    assign u_cur = pend_reg ? anc_a : u_reg;

    // Second pass: step both nodes up while their ancestors differ
    assign u_pass = (anc_a != anc_b) ? anc_a : u_reg;
    assign v_pass = (anc_a != anc_b) ? anc_b : v_reg;

    assign dsum    = {1'b0, inf_a.root_dist} + (DIST_W + 1)'(weight_reg);
    assign pdiff   = {1'b0, sum_reg} - {1'b0, inf_a.root_dist, 1'b0};
    assign gap_raw = (inf_a.depth < inf_b.depth) ? (inf_b.depth - inf_a.depth)
                                                 : (inf_a.depth - inf_b.depth);

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        node_next    = node_reg;
        par_next     = par_reg;
        weight_next  = weight_reg;
        u_next       = u_reg;
        v_next       = v_reg;
        lca_next     = lca_reg;
        lvl_next     = lvl_reg;
        gap_next     = gap_reg;
        pend_next    = pend_reg;
        sum_next     = sum_reg;
        m_lca_next   = m_lca_reg;
        m_dist_next  = m_dist_reg;
        m_diff_next  = m_diff_reg;
        m_valid_next = m_valid_reg && !m_tready;
        rd_node_a    = u_reg;
        rd_node_b    = v_reg;
        rd_lvl       = lvl_reg;
        inf_we       = 1'b0;
        inf_wdata    = '0;
        anc_we       = 1'b0;
        anc_wdata    = par_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    node_next   = in_node_a;
                    par_next    = b_idx;
                    weight_next = in_weight & WMASK;
                    u_next      = a_idx;
                    v_next      = b_idx;
                    lvl_next    = '0;
                    if (s_tuser[0] == REQ_QUERY) begin
                        state_next = ST_Q_INFO;
                    end else if (add_ok) begin
                        state_next = ST_A_INFO;
                    end
                end
            end
            // Parent record read; level 0 entry is the parent itself
            ST_A_INFO: begin
                rd_node_a  = par_reg;
                anc_we     = 1'b1;
                anc_wdata  = par_reg;
                lvl_next   = LVL_W'(1);
                state_next = ST_A_INFOWR;
            end
            ST_A_INFOWR: begin
                inf_we = 1'b1;
                if (par_reg != '0) begin
                    inf_wdata.depth = (inf_a.depth == DEPTH_MAX) ? DEPTH_MAX
                                                                 : inf_a.depth + 1'b1;
                    inf_wdata.root_dist = dsum[DIST_W] ? DIST_MAX : dsum[DIST_W-1:0];
                end
                rd_node_a  = par_reg;
                rd_lvl     = '0;
                state_next = ST_A_WR;
            end
            // Entry lvl = entry lvl-1 of the previous ancestor
            ST_A_WR: begin
                anc_we    = 1'b1;
                anc_wdata = anc_a;
                u_next    = anc_a;
                if (lvl_reg == LAST_LVL) begin
                    state_next = ST_IDLE;
                end else begin
                    lvl_next   = lvl_reg + LVL_W'(1);
                    state_next = ST_A_RD;
                end
            end
            ST_A_RD: begin
                rd_lvl     = lvl_reg - LVL_W'(1);
                state_next = ST_A_WR;
            end
            ST_Q_INFO: begin
                state_next = ST_Q_SWAP;
            end
            // Deeper node goes to u
            ST_Q_SWAP: begin
                sum_next = {1'b0, inf_a.root_dist} + {1'b0, inf_b.root_dist};
                if (inf_a.depth < inf_b.depth) begin
                    u_next = v_reg;
                    v_next = u_reg;
                end
                gap_next   = LEVELS'(gap_raw);
                lvl_next   = LAST_LVL;
                pend_next  = 1'b0;
                state_next = ST_Q_LIFT;
            end
            // Lift u by the set bits of the depth gap, highest level first
            ST_Q_LIFT: begin
                rd_node_a = u_cur;
                u_next    = u_cur;
                pend_next = gap_reg[lvl_reg];
                if (lvl_reg == '0) begin
                    state_next = ST_Q_CHECK;
                end else begin
                    lvl_next = lvl_reg - LVL_W'(1);
                end
            end
            ST_Q_CHECK: begin
                rd_node_a = u_cur;
                u_next    = u_cur;
                if (u_cur == v_reg) begin
                    lca_next   = u_cur;
                    state_next = ST_Q_DIST;
                end else begin
                    rd_lvl     = LAST_LVL;
                    lvl_next   = LAST_LVL;
                    state_next = ST_Q_PASS;
                end
            end
            ST_Q_PASS: begin
                u_next    = u_pass;
                v_next    = v_pass;
                rd_node_a = u_pass;
                rd_node_b = v_pass;
                if (lvl_reg == '0) begin
                    rd_lvl     = '0;
                    state_next = ST_Q_PAR;
                end else begin
                    rd_lvl   = lvl_reg - LVL_W'(1);
                    lvl_next = lvl_reg - LVL_W'(1);
                end
            end
            ST_Q_PAR: begin
                lca_next   = anc_a;
                rd_node_a  = anc_a;
                state_next = ST_Q_DIST;
            end
            // Distance from the root sums; hold the read while the output is full
            ST_Q_DIST: begin
                rd_node_a = lca_reg;
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_lca_next   = lca_reg;
                    m_diff_next  = (lca_reg == '0);
                    if (lca_reg == '0 || pdiff[DIST_W+1]) begin
                        m_dist_next = '0;
                    end else if (pdiff[DIST_W]) begin
                        m_dist_next = DIST_MAX;
                    end else begin
                        m_dist_next = pdiff[DIST_W-1:0];
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        node_reg   <= node_next;
        par_reg    <= par_next;
        weight_reg <= weight_next;
        u_reg      <= u_next;
        v_reg      <= v_next;
        lca_reg    <= lca_next;
        lvl_reg    <= lvl_next;
        gap_reg    <= gap_next;
        pend_reg   <= pend_next;
        sum_reg    <= sum_next;
        za_reg     <= (rd_node_a == '0);
        zb_reg     <= (rd_node_b == '0);
        m_lca_reg  <= m_lca_next;
        m_dist_reg <= m_dist_next;
        m_diff_reg <= m_diff_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0, m_dist_reg, m_lca_reg};
    assign m_tuser  = m_diff_reg;

endmodule

`default_nettype wire

// ----- src/lca_ram.sv -----
`default_nettype none

module lca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    ra_addr,
    output logic      [WIDTH-1:0] ra_data,
    input  wire logic [AW-1:0]    rb_addr,
    output logic      [WIDTH-1:0] rb_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, two registered read ports (read returns old data)
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        ra_data <= mem[ra_addr];
        rb_data <= mem[rb_addr];
    end

endmodule

`default_nettype wire

// ----- src/lca_checker.sv -----
`default_nettype none

module lca_checker
    import lca_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [39:0] s_tdata,
    input wire logic [0:0]  s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata,
    input wire logic [0:0]  m_tuser
);

    // No result right after a reset cycle
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Split-forest result carries no ancestor and no distance
    a_split_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[35:0] == 36'd0)
        else $error("split-forest result not zero");

    // Sentinel ancestor always flags split forest
    a_zero_lca: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[9:0] == 10'd0 |-> m_tuser[0])
        else $error("lca 0 without flag");

    // A query transfer occupies the sequencer for the next cycle
    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser[0] == REQ_QUERY |=> !s_tready)
        else $error("ready right after query");

endmodule

bind tree_lca_distance_engine_unit lca_checker u_lca_checker (.*);

`default_nettype wire
